/* hw/rtl/perspective_world_to_screen_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the perspective projection block
// Compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PWS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PWS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PWS_ASSERT(label, clk, rst_n, prop)
`define PWS_ASSERT_RST(label, clk, prop)
`endif
`endif

/* hw/rtl/pws_pkg.sv */
// ---------------------------------------------------------------------------
// pws_pkg
// Shared types and constants of the perspective projection block.
// ---------------------------------------------------------------------------
package pws_pkg;
  localparam int unsigned ScreenBitsDefault = 12;
  localparam int unsigned DivStages = 20;  // quotient bits; covers SCREEN_BITS up to 16

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;
endpackage

/* hw/rtl/pws_if.sv */
// ---------------------------------------------------------------------------
// pws_in_if / pws_out_if / pws_cfg_if
// Valid/ready channels of the projection block.
// ---------------------------------------------------------------------------
interface pws_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                output ready);
endinterface

interface pws_out_if #(parameter int unsigned SCREEN_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic                   was_point;
  logic                   visible;
  logic [SCREEN_BITS-1:0] screen_x;
  logic [SCREEN_BITS-1:0] screen_y;
  modport source (output valid, was_point, visible, screen_x, screen_y, input ready);
  modport sink (input valid, was_point, visible, screen_x, screen_y, output ready);
endinterface

interface pws_cfg_if #(parameter int unsigned SCREEN_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [1:0]             index;
  logic [SCREEN_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/pws_front.sv */
// ---------------------------------------------------------------------------
// pws_front
// Holds the matrix, classifies words and forms clip x, y, w (2 stages).
// ---------------------------------------------------------------------------
module pws_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic        op_i,
  input  logic [3:0]  coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic        valid_o,
  output logic        point_o,
  output logic signed [49:0] cx_o,
  output logic signed [49:0] cy_o,
  output logic signed [49:0] cw_o
);
  logic signed [31:0] mat_q [16];
  logic [1:0] v_q;
  logic [1:0] p_q;
  logic signed [63:0] prod_q [9];
  logic signed [31:0] tr_q [3];
  logic signed [49:0] cx_q, cy_q, cw_q;
  logic signed [31:0] pin [3];

  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
      v_q <= '0;
      p_q <= '0;
    end else if (en_i) begin
      if (valid_i && (op_i == pws_pkg::OP_LOAD)) mat_q[coef_index_i] <= coef_value_i;
      v_q <= {v_q[0], valid_i};
      p_q <= {p_q[0], valid_i && (op_i == pws_pkg::OP_POINT)};
    end
  end

  // rows 0, 1, 3 of the column-major matrix
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c]     <= mat_q[4*c]     * pin[c];
        prod_q[3 + c] <= mat_q[4*c + 1] * pin[c];
        prod_q[6 + c] <= mat_q[4*c + 3] * pin[c];
      end
      tr_q[0] <= mat_q[12];
      tr_q[1] <= mat_q[13];
      tr_q[2] <= mat_q[15];
      cx_q <= 50'(tr_q[0]) + 50'(prod_q[0] >>> 16) + 50'(prod_q[1] >>> 16)
              + 50'(prod_q[2] >>> 16);
      cy_q <= 50'(tr_q[1]) + 50'(prod_q[3] >>> 16) + 50'(prod_q[4] >>> 16)
              + 50'(prod_q[5] >>> 16);
      cw_q <= 50'(tr_q[2]) + 50'(prod_q[6] >>> 16) + 50'(prod_q[7] >>> 16)
              + 50'(prod_q[8] >>> 16);
    end
  end

  assign valid_o = v_q[1];
  assign point_o = p_q[1];
  assign cx_o = cx_q;
  assign cy_o = cy_q;
  assign cw_o = cw_q;
endmodule

/* hw/rtl/pws_back.sv */
// ---------------------------------------------------------------------------
// pws_back
// Range test, pixel numerators and a pipelined restoring divider.
// ---------------------------------------------------------------------------
module pws_back #(
  parameter int unsigned SCREEN_BITS = pws_pkg::ScreenBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic        point_i,
  input  logic signed [49:0] cx_i,
  input  logic signed [49:0] cy_i,
  input  logic signed [49:0] cw_i,
  input  logic [SCREEN_BITS-1:0] width_i,
  input  logic [SCREEN_BITS-1:0] height_i,
  output logic        valid_o,
  output logic        was_point_o,
  output logic        visible_o,
  output logic [SCREEN_BITS-1:0] screen_x_o,
  output logic [SCREEN_BITS-1:0] screen_y_o
);
  localparam int unsigned N = pws_pkg::DivStages;
  localparam int unsigned NW = 51 + SCREEN_BITS;  // numerator width
  localparam int unsigned RW = 51;

  // stage A: visibility and sums
  logic a_v_q, a_p_q, a_vis_q;
  logic [50:0] a_sx_q, a_sy_q;
  logic [49:0] a_w_q;
  logic [SCREEN_BITS-2:0] a_hw_q, a_hh_q;
  // stage B: numerators
  logic b_v_q, b_p_q, b_vis_q;
  logic [NW-1:0] b_nx_q, b_ny_q;
  logic [49:0] b_w_q;
  // divider stages
  logic [N:0] d_v_q, d_p_q, d_vis_q;
  logic [RW-1:0] rx_q [N+1], ry_q [N+1];
  logic [NW-1:0] nx_q [N+1], ny_q [N+1];
  logic [N-1:0] qx_q [N+1], qy_q [N+1];
  logic [49:0] dw_q [N+1];

  logic vis_c;
  assign vis_c = (cw_i > 0) && (cx_i < cw_i) && (cx_i > -cw_i)
                 && (cy_i < cw_i) && (cy_i > -cw_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      d_v_q <= '0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      d_v_q <= {d_v_q[N-1:0], b_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_p_q   <= point_i;
      a_vis_q <= point_i && vis_c;
      a_sx_q  <= 51'(cx_i + cw_i);
      a_sy_q  <= 51'(cw_i - cy_i);
      a_w_q   <= cw_i;
      a_hw_q  <= width_i[SCREEN_BITS-1:1];
      a_hh_q  <= height_i[SCREEN_BITS-1:1];
      b_p_q   <= a_p_q;
      b_vis_q <= a_vis_q;
      b_nx_q  <= NW'(a_sx_q) * NW'(a_hw_q);
      b_ny_q  <= NW'(a_sy_q) * NW'(a_hh_q);
      b_w_q   <= a_w_q;
      d_p_q[0] <= b_p_q;
      d_vis_q[0] <= b_vis_q;
      rx_q[0] <= RW'(b_nx_q >> N);
      ry_q[0] <= RW'(b_ny_q >> N);
      nx_q[0] <= b_nx_q;
      ny_q[0] <= b_ny_q;
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      dw_q[0] <= b_w_q;
      // quotient < 2^N, so high part already below w; one bit per stage
      for (int s = 0; s < N; s++) begin
        logic [RW:0] tx, ty;
        tx = {rx_q[s], nx_q[s][N-1-s]};
        ty = {ry_q[s], ny_q[s][N-1-s]};
        d_p_q[s+1] <= d_p_q[s];
        d_vis_q[s+1] <= d_vis_q[s];
        nx_q[s+1] <= nx_q[s];
        ny_q[s+1] <= ny_q[s];
        dw_q[s+1] <= dw_q[s];
        if (tx >= {2'b0, dw_q[s]}) begin
          rx_q[s+1] <= RW'(tx - {2'b0, dw_q[s]});
          qx_q[s+1] <= {qx_q[s][N-2:0], 1'b1};
        end else begin
          rx_q[s+1] <= RW'(tx);
          qx_q[s+1] <= {qx_q[s][N-2:0], 1'b0};
        end
        if (ty >= {2'b0, dw_q[s]}) begin
          ry_q[s+1] <= RW'(ty - {2'b0, dw_q[s]});
          qy_q[s+1] <= {qy_q[s][N-2:0], 1'b1};
        end else begin
          ry_q[s+1] <= RW'(ty);
          qy_q[s+1] <= {qy_q[s][N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o     = d_v_q[N];
  assign was_point_o = d_p_q[N];
  assign visible_o   = d_vis_q[N];
  assign screen_x_o  = d_vis_q[N] ? qx_q[N][SCREEN_BITS-1:0] : '0;
  assign screen_y_o  = d_vis_q[N] ? qy_q[N][SCREEN_BITS-1:0] : '0;
endmodule

/* hw/rtl/pws_queue.sv */
// ---------------------------------------------------------------------------
// pws_queue
// Result queue; deep enough to drain the whole pipeline when stalled.
// ---------------------------------------------------------------------------
module pws_queue #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= AW'(wp_q + 1'b1);
      if (pop_i) rp_q <= AW'(rp_q + 1'b1);
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
  assign data_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

/* hw/rtl/perspective_world_to_screen.sv */
// ---------------------------------------------------------------------------
// perspective_world_to_screen
// Projects Q16.16 world points to screen pixels through a 4x4 matrix.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : a load word (op 0) writes one matrix entry, a point word (op 1)
//            projects x, y, z. Every word yields one result word.
//   out_if : was_point, visible, screen_x, screen_y.
//   cfg_if : index 0 sets screen width, index 1 screen height; other
//            indices are ignored. Write only while idle.
// An accepted input word passes the front, the back, the divider and the
// result queue in that order before its result word is offered. Throughput:
// one word per cycle while the receiver keeps up.
// The front computes clip x, y, w with nine 32x32 multipliers; the back
// runs a 20-stage restoring divider, one quotient bit per stage.
// A 32-entry result queue sits after the pipeline; input ready drops when
// the queue plus in-flight words could overflow it, so a stalled receiver
// never loses a word. Reset clears the matrix to zero and sets 1024 x 768.
// ---------------------------------------------------------------------------
`include "perspective_world_to_screen_macros.svh"

module perspective_world_to_screen #(
  parameter int unsigned SCREEN_BITS = pws_pkg::ScreenBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  pws_in_if.sink   in_if,
  pws_out_if.source out_if,
  pws_cfg_if.sink  cfg_if
);
  localparam int unsigned Lat = 6 + pws_pkg::DivStages;  // upper bound on words in flight
  localparam int unsigned QDepth = 32;
  localparam int unsigned RW = 2 + 2 * SCREEN_BITS;

  logic [SCREEN_BITS-1:0] width_q, height_q;
  logic f_v, f_p, b_v, b_p, b_vis;
  logic signed [49:0] cx, cy, cw;
  logic [SCREEN_BITS-1:0] sx, sy;
  logic [RW-1:0] q_out;
  logic q_empty, pop, acc;
  logic [$clog2(QDepth+1)-1:0] q_cnt;
  logic [$clog2(Lat+1)-1:0] fly_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_BITS'(1024);
      height_q <= SCREEN_BITS'(768);
    end else if (cfg_if.valid) begin
      if (cfg_if.index == 2'(pws_pkg::REG_WIDTH)) width_q <= cfg_if.data;
      else if (cfg_if.index == 2'(pws_pkg::REG_HEIGHT)) height_q <= cfg_if.data;
    end
  end

  // words in flight in the pipeline (pipeline always advances)
  assign in_if.ready = (32'(q_cnt) + 32'(fly_q) + 1) <= QDepth;
  assign acc = in_if.valid && in_if.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fly_q <= '0;
    else fly_q <= fly_q + (acc ? 1'b1 : 1'b0) - (b_v ? 1'b1 : 1'b0);
  end

  pws_front u_front (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(acc), .op_i(in_if.op),
    .coef_index_i(in_if.coef_index), .coef_value_i(in_if.coef_value),
    .point_x_i(in_if.point_x), .point_y_i(in_if.point_y), .point_z_i(in_if.point_z),
    .valid_o(f_v), .point_o(f_p), .cx_o(cx), .cy_o(cy), .cw_o(cw)
  );

  pws_back #(.SCREEN_BITS(SCREEN_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(f_v), .point_i(f_p),
    .cx_i(cx), .cy_i(cy), .cw_i(cw), .width_i(width_q), .height_i(height_q),
    .valid_o(b_v), .was_point_o(b_p), .visible_o(b_vis),
    .screen_x_o(sx), .screen_y_o(sy)
  );

  assign pop = out_if.valid && out_if.ready;
  pws_queue #(.WIDTH(RW), .DEPTH(QDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(b_v), .data_i({b_p, b_vis, sx, sy}),
    .pop_i(pop), .data_o(q_out), .empty_o(q_empty), .count_o(q_cnt)
  );

  assign out_if.valid     = !q_empty;
  assign out_if.was_point = q_out[RW-1];
  assign out_if.visible   = q_out[RW-2];
  assign out_if.screen_x  = q_out[2*SCREEN_BITS-1:SCREEN_BITS];
  assign out_if.screen_y  = q_out[SCREEN_BITS-1:0];

  `PWS_ASSERT(a_no_overflow, clk_i, rst_ni, (32'(q_cnt) + 32'(fly_q)) <= QDepth)
  `PWS_ASSERT(a_vis_point, clk_i, rst_ni, (b_v && b_vis) |-> b_p)
  `PWS_ASSERT_RST(a_rst_empty, clk_i, !rst_ni |=> !out_if.valid)
endmodule

/* sim/perspective_world_to_screen_checker.sv */
// ---------------------------------------------------------------------------
// perspective_world_to_screen_checker
// Watches the input, output and config channels of the projection block,
// keeps its own copy of the matrix and viewport, predicts each result word
// and compares it with what the block returns.
// ---------------------------------------------------------------------------
module perspective_world_to_screen_checker #(
  parameter int unsigned SCREEN_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  pws_in_if.sink   in_if,
  pws_out_if.sink  out_if,
  pws_cfg_if.sink  cfg_if,
  output int       fail_count_o,
  output int       pending_o
);
  typedef struct packed {
    logic                   was_point;
    logic                   visible;
    logic [SCREEN_BITS-1:0] screen_x;
    logic [SCREEN_BITS-1:0] screen_y;
  } pixel_t;

  logic signed [31:0]     coef_mem [16];
  logic [SCREEN_BITS-1:0] view_w, view_h;
  pixel_t                 pixel_q[$];

  // floor of a Q32.32 product back to Q16.16 (arith shift floors)
  function automatic logic signed [63:0] mul_q16(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] clip_row(int r, logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
    return 64'(coef_mem[12 + r]) + mul_q16(coef_mem[r], x)
           + mul_q16(coef_mem[4 + r], y) + mul_q16(coef_mem[8 + r], z);
  endfunction

  function automatic pixel_t project(logic signed [31:0] x, logic signed [31:0] y,
                                     logic signed [31:0] z);
    pixel_t             res;
    logic signed [63:0] cx, cy, cw;
    logic [127:0]       num;
    res = '0;
    res.was_point = 1'b1;
    cx = clip_row(0, x, y, z);
    cy = clip_row(1, x, y, z);
    cw = clip_row(3, x, y, z);
    if (cw > 0 && cx < cw && cx > -cw && cy < cw && cy > -cw) begin
      res.visible = 1'b1;
      num = 128'(cx + cw) * 128'(view_w >> 1);
      res.screen_x = SCREEN_BITS'(num / 128'(cw));
      num = 128'(cw - cy) * 128'(view_h >> 1);
      res.screen_y = SCREEN_BITS'(num / 128'(cw));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) coef_mem[i] = '0;
      view_w = SCREEN_BITS'(1024);
      view_h = SCREEN_BITS'(768);
      pixel_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == 2'(pws_pkg::REG_WIDTH)) view_w = cfg_if.data;
        else if (cfg_if.index == 2'(pws_pkg::REG_HEIGHT)) view_h = cfg_if.data;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.was_point, out_if.visible, out_if.screen_x, out_if.screen_y};
        if (pixel_q.size() == 0) begin
          $error("unexpected result word");
          fail_count_o++;
        end else begin
          want = pixel_q.pop_front();
          if (got.was_point !== want.was_point) begin
            $error("was_point: expected %0d, got %0d", want.was_point, got.was_point);
            fail_count_o++;
          end
          if (got.visible !== want.visible) begin
            $error("visible: expected %0d, got %0d", want.visible, got.visible);
            fail_count_o++;
          end
          if (got.screen_x !== want.screen_x) begin
            $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
            fail_count_o++;
          end
          if (got.screen_y !== want.screen_y) begin
            $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
            fail_count_o++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.op == pws_pkg::OP_LOAD) begin
          coef_mem[in_if.coef_index] = in_if.coef_value;
          want = '0;
        end else begin
          want = project(in_if.point_x, in_if.point_y, in_if.point_z);
        end
        pixel_q = {pixel_q, want};
      end
      pending_o = pixel_q.size();
    end
  end
endmodule

/* sim/perspective_world_to_screen_tb.sv */
// ---------------------------------------------------------------------------
// perspective_world_to_screen_tb
// Drives loads, projections and viewport writes into the projection block
// under random idling on both sides; the checker judges every result word.
// ---------------------------------------------------------------------------
module perspective_world_to_screen_tb;
  localparam int unsigned SB        = 12;
  localparam int          MaxCycles = 400000;
  localparam int          Drain     = 40;   // settle time after the last result word

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, cycle_cnt;
  int   src_idle, snk_idle;  // idle percentages

  pws_in_if           in_if ();
  pws_out_if #(SB)    out_if ();
  pws_cfg_if #(SB)    cfg_if ();

  perspective_world_to_screen #(.SCREEN_BITS(SB)) i_dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source), .cfg_if(cfg_if.sink)
  );

  perspective_world_to_screen_checker #(.SCREEN_BITS(SB)) i_checker (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.sink), .cfg_if(cfg_if.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  // valid stays high on return; an idle in the next call or a drain drops it
  task automatic send_word(pws_pkg::op_e op, logic [3:0] idx, logic [31:0] coef,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.coef_index <= idx;
    in_if.coef_value <= coef;
    in_if.point_x    <= x;
    in_if.point_y    <= y;
    in_if.point_z    <= z;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic load_coef(int idx, logic [31:0] v);
    send_word(pws_pkg::OP_LOAD, 4'(idx), v, $urandom, $urandom, $urandom);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(pws_pkg::OP_POINT, 4'($urandom), $urandom, x, y, z);
  endtask

  // wait for every result word, then let the pipeline settle
  task automatic drain_all();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [SB-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // a plain perspective-like matrix with random scale, so most points land
  // in front and many inside the view
  task automatic load_camera();
    for (int i = 0; i < 16; i++) begin
      case (i)
        0, 5:    load_coef(i, 32'($urandom_range(32'h0002_0000, 32'h0000_4000)));
        11:      load_coef(i, 32'h0001_0000);
        12, 13:  load_coef(i, 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000));
        15:      load_coef(i, 32'($urandom_range(32'h0002_0000)));
        default: load_coef(i, ($urandom_range(3) == 0) ? $urandom : 32'h0);
      endcase
    end
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 8) load_coef($urandom_range(15), $urandom);          // noise load
      else if (r < 12) send_point($urandom, $urandom, $urandom);   // wild point
      else send_point($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000,
                      $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000,
                      $urandom_range(32'h0010_0000, 32'h0000_1000));
    end
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.op = pws_pkg::OP_LOAD; in_if.coef_index = '0;
    in_if.coef_value = '0; in_if.point_x = '0; in_if.point_y = '0; in_if.point_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    src_idle = 29; snk_idle = 54;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero matrix after reset means w is 0, never visible
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    // identity-like matrix: w = z
    load_coef(0, 32'h0001_0000); load_coef(5, 32'h0001_0000);
    load_coef(11, 32'h0001_0000);
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_0000);  // inside
    send_point(32'h0001_0000, 32'h0, 32'h0001_0000);          // on the edge
    send_point(32'h0, 32'h0, 32'hffff_0000);                  // behind
    send_point(32'h0, 32'h0, 32'h0);                          // w zero
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);  // extremes
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_coef(15, 32'h7fff_ffff); load_coef(12, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    load_coef(12, 32'h0); load_coef(15, 32'h0);
    send_point(32'hffff_0001, 32'h0000_ffff, 32'h0002_0000);
    drain_all();

    // viewport extremes: a half of zero pins that axis to 0
    write_reg(2'(pws_pkg::REG_WIDTH), SB'(1));
    write_reg(2'(pws_pkg::REG_HEIGHT), SB'(0));
    write_reg(2'd3, SB'(5));  // index beyond the list: ignored
    send_point(32'h0000_4000, 32'h0000_4000, 32'h0001_0000);
    drain_all();
    write_reg(2'(pws_pkg::REG_WIDTH), SB'(4095));
    write_reg(2'(pws_pkg::REG_HEIGHT), SB'(4095));
    send_point(32'h0000_ffff, 32'hffff_0001, 32'h0001_0000);
    send_point(32'hffff_0001, 32'h0000_ffff, 32'h0001_0000);
    drain_all();

    // random, sender idles less than the receiver
    load_camera();
    random_phase(550);
    drain_all();

    write_reg(2'(pws_pkg::REG_WIDTH), SB'($urandom_range(4095, 1)));
    write_reg(2'(pws_pkg::REG_HEIGHT), SB'($urandom_range(4095, 1)));
    src_idle = 54; snk_idle = 29;
    load_camera();
    random_phase(275);
    // sender holds off until every result has come
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    random_phase(275);
    drain_all();

    write_reg(2'(pws_pkg::REG_WIDTH), SB'(2));
    write_reg(2'(pws_pkg::REG_HEIGHT), SB'(3));
    src_idle = 0; snk_idle = 0;
    load_camera();
    random_phase(200);
    drain_all();
    write_reg(2'(pws_pkg::REG_WIDTH), SB'(1920));
    write_reg(2'(pws_pkg::REG_HEIGHT), SB'(1080));
    load_camera();
    random_phase(350);
    drain_all();

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
